// ----- rtl/cpnc_pkg.sv -----
// Package for the capability probe negative cache: default widths, mode type,
// operation and observation codes, and the decision struct.
// No dependencies.
package cpnc_pkg;

  // Default widths of time values and of the epoch counter.
  localparam int TIME_WIDTH_DEF  = 48;
  localparam int EPOCH_WIDTH_DEF = 32;

  // Configuration register indexes.
  localparam int CFG_INDEX_WIDTH = 1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNAVAILABLE_TTL = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_JITTER      = 1'd1;

  // Operation codes.
  localparam logic [1:0] OP_BEGIN   = 2'd0;
  localparam logic [1:0] OP_FINISH  = 2'd1;
  localparam logic [1:0] OP_ABANDON = 2'd2;

  // Observation codes; any other code is treated as another outcome.
  localparam logic [1:0] OBS_AVAILABLE   = 2'd0;
  localparam logic [1:0] OBS_UNAVAILABLE = 2'd1;

  // Capability mode of the direct path.
  typedef enum logic [1:0] {
    MODE_UNKNOWN     = 2'd0,
    MODE_PROBING     = 2'd1,
    MODE_AVAILABLE   = 2'd2,
    MODE_UNAVAILABLE = 2'd3
  } mode_t;

  // Decision for one item, handed from the decision logic to the state update.
  typedef struct packed {
    mode_t mode_nxt;     // mode after the item
    logic  bump;         // mode changed: advance the epoch
    logic  mark;         // change is to unavailable: load the new deadline
    logic  path_direct;  // begin result: strict direct path
    logic  is_probe;     // begin result: this attempt is the probe
  } ctrl_t;

endpackage

// ----- rtl/cpnc_decide.sv -----
// Mode decision for one item of the capability probe negative cache.
// Depends on cpnc_pkg for the mode type, codes and the decision struct.
module cpnc_decide (
  input  logic [1:0]     op,
  input  cpnc_pkg::mode_t mode,
  input  logic           fault,
  input  logic           epoch_match,
  input  logic           deadline_reached,
  input  logic           attempt_probe,
  input  logic           attempt_direct,
  input  logic [1:0]     observation,
  input  logic           zero_bytes,
  output cpnc_pkg::ctrl_t ctrl
);

  logic start_probe;
  logic strict;
  logic go_unavail;

  // A strict result is an unavailable outcome with no bytes on either count.
  assign strict = (observation == cpnc_pkg::OBS_UNAVAILABLE) && zero_bytes;

  // Pick the next mode and the begin results from the current mode and the item.
  always_comb begin
    ctrl             = '0;
    ctrl.mode_nxt    = mode;
    start_probe      = 1'b0;
    go_unavail       = 1'b0;
    case (op)
      cpnc_pkg::OP_BEGIN: begin
        case (mode)
          cpnc_pkg::MODE_UNKNOWN:     start_probe = 1'b1;
          cpnc_pkg::MODE_AVAILABLE:   ctrl.path_direct = 1'b1;
          cpnc_pkg::MODE_UNAVAILABLE: start_probe = deadline_reached;
          default:                    ;
        endcase
        if (start_probe) begin
          ctrl.mode_nxt    = cpnc_pkg::MODE_PROBING;
          ctrl.bump        = 1'b1;
          ctrl.path_direct = 1'b1;
          ctrl.is_probe    = 1'b1;
        end
      end
      cpnc_pkg::OP_FINISH: begin
        // Only a direct attempt from the current epoch carries news.
        if (attempt_direct && epoch_match) begin
          if (attempt_probe) begin
            if (mode == cpnc_pkg::MODE_PROBING) begin
              if (observation == cpnc_pkg::OBS_AVAILABLE) begin
                ctrl.mode_nxt = cpnc_pkg::MODE_AVAILABLE;
                ctrl.bump     = 1'b1;
              end else if (!strict) begin
                ctrl.mode_nxt = cpnc_pkg::MODE_UNKNOWN;
                ctrl.bump     = 1'b1;
              end else begin
                go_unavail = 1'b1;
              end
            end
          end else if (mode == cpnc_pkg::MODE_AVAILABLE && strict) begin
            go_unavail = 1'b1;
          end
        end
        // A clock fault cannot set a deadline, so the mode falls back to unknown.
        if (go_unavail) begin
          ctrl.bump = 1'b1;
          if (fault) begin
            ctrl.mode_nxt = cpnc_pkg::MODE_UNKNOWN;
          end else begin
            ctrl.mode_nxt = cpnc_pkg::MODE_UNAVAILABLE;
            ctrl.mark     = 1'b1;
          end
        end
      end
      cpnc_pkg::OP_ABANDON: begin
        if (attempt_probe && mode == cpnc_pkg::MODE_PROBING && epoch_match) begin
          ctrl.mode_nxt = cpnc_pkg::MODE_UNKNOWN;
          ctrl.bump     = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/capability_probe_negative_cache_core.sv -----
// Capability probe negative cache: input register, decision and state update,
// result register. Depends on cpnc_pkg and cpnc_decide.
// An item passes through the input register and then the result register.
// Throughput: one item per cycle while the result register is drained; the mode,
// epoch and deadline registers are updated in the same cycle an item is decided, so the next item sees them.
// Reset (rst_n low, synchronous): mode unknown, epoch and deadline zero,
// both configuration registers zero, no item held.
module capability_probe_negative_cache_core #(
  parameter int TIME_WIDTH  = cpnc_pkg::TIME_WIDTH_DEF,
  parameter int EPOCH_WIDTH = cpnc_pkg::EPOCH_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic [cpnc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [TIME_WIDTH-1:0]                cfg_wdata,
  // Input channel.
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_op,
  input  logic [TIME_WIDTH-1:0]                in_now_time,
  input  logic                                 in_clock_fault,
  input  logic [TIME_WIDTH-1:0]                in_jitter_value,
  input  logic [EPOCH_WIDTH-1:0]               in_attempt_epoch,
  input  logic                                 in_attempt_probe,
  input  logic                                 in_attempt_direct,
  input  logic [1:0]                           in_observation,
  input  logic [TIME_WIDTH-1:0]                in_body_bytes,
  input  logic [TIME_WIDTH-1:0]                in_direct_body_bytes,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_path_direct,
  output logic                                 out_is_probe,
  output logic [EPOCH_WIDTH-1:0]               out_epoch_now,
  output logic [1:0]                           out_mode_now,
  output logic [TIME_WIDTH-1:0]                out_deadline_now
);

  // Configuration registers.
  logic [TIME_WIDTH-1:0] ttl_r;
  logic [TIME_WIDTH-1:0] max_jitter_r;

  // Input stage.
  logic                   s1_valid_r;
  logic [1:0]             s1_op_r;
  logic [TIME_WIDTH-1:0]  s1_now_r;
  logic                   s1_fault_r;
  logic [TIME_WIDTH-1:0]  s1_delay_r;
  logic [EPOCH_WIDTH-1:0] s1_epoch_r;
  logic                   s1_probe_r;
  logic                   s1_direct_r;
  logic [1:0]             s1_obs_r;
  logic                   s1_zero_r;

  // Cache state.
  cpnc_pkg::mode_t        mode_r, mode_nxt;
  logic [EPOCH_WIDTH-1:0] epoch_r, epoch_nxt;
  logic [TIME_WIDTH-1:0]  deadline_r, deadline_nxt;

  // Result register.
  logic                   out_valid_r;
  logic                   out_path_direct_r;
  logic                   out_is_probe_r;
  logic [EPOCH_WIDTH-1:0] out_epoch_now_r;
  logic [1:0]             out_mode_now_r;
  logic [TIME_WIDTH-1:0]  out_deadline_now_r;

  // Handshake and datapath signals.
  logic                   out_free;
  logic                   proc;
  logic                   in_xfer;
  logic [TIME_WIDTH-1:0]  jitter_clamped;
  logic [TIME_WIDTH:0]    delay_sum;
  logic [TIME_WIDTH-1:0]  delay_sat;
  logic [TIME_WIDTH:0]    until_sum;
  logic [TIME_WIDTH-1:0]  until_sat;
  logic                   epoch_match;
  logic                   deadline_reached;
  cpnc_pkg::ctrl_t        ctrl;

  // The input stage moves on when the result register is empty or being drained.
  assign out_free = !out_valid_r || out_ready;
  assign proc     = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_xfer  = in_valid && in_ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r        <= '0;
      max_jitter_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cpnc_pkg::REG_UNAVAILABLE_TTL: ttl_r        <= cfg_wdata;
        cpnc_pkg::REG_MAX_JITTER:      max_jitter_r <= cfg_wdata;
        default:                       ;
      endcase
    end
  end

  // Clamp the jitter and add the ttl ahead of time; neither depends on state.
  assign jitter_clamped = (in_jitter_value > max_jitter_r) ? max_jitter_r : in_jitter_value;
  assign delay_sum      = {1'b0, ttl_r} + {1'b0, jitter_clamped};
  assign delay_sat      = delay_sum[TIME_WIDTH] ? '1 : delay_sum[TIME_WIDTH-1:0];

  // Input stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (proc) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r     <= in_op;
      s1_now_r    <= in_now_time;
      s1_fault_r  <= in_clock_fault;
      s1_delay_r  <= delay_sat;
      s1_epoch_r  <= in_attempt_epoch;
      s1_probe_r  <= in_attempt_probe;
      s1_direct_r <= in_attempt_direct;
      s1_obs_r    <= in_observation;
      s1_zero_r   <= (in_body_bytes == '0) && (in_direct_body_bytes == '0);
    end
  end

  // Compares against the current state and the saturating new deadline.
  assign epoch_match      = (s1_epoch_r == epoch_r);
  assign deadline_reached = s1_fault_r || (s1_now_r >= deadline_r);
  assign until_sum        = {1'b0, s1_now_r} + {1'b0, s1_delay_r};
  assign until_sat        = until_sum[TIME_WIDTH] ? '1 : until_sum[TIME_WIDTH-1:0];

  cpnc_decide u_decide (
    .op               (s1_op_r),
    .mode             (mode_r),
    .fault            (s1_fault_r),
    .epoch_match      (epoch_match),
    .deadline_reached (deadline_reached),
    .attempt_probe    (s1_probe_r),
    .attempt_direct   (s1_direct_r),
    .observation      (s1_obs_r),
    .zero_bytes       (s1_zero_r),
    .ctrl             (ctrl)
  );

  // Next state: every mode change advances the epoch and reloads the deadline.
  always_comb begin
    mode_nxt     = mode_r;
    epoch_nxt    = epoch_r;
    deadline_nxt = deadline_r;
    if (proc && ctrl.bump) begin
      mode_nxt     = ctrl.mode_nxt;
      epoch_nxt    = epoch_r + 1'b1;
      deadline_nxt = ctrl.mark ? until_sat : '0;
    end
  end

  // State registers and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= cpnc_pkg::MODE_UNKNOWN;
      epoch_r     <= '0;
      deadline_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      epoch_r    <= epoch_nxt;
      deadline_r <= deadline_nxt;
      if (proc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, captured with the state after the item.
  always_ff @(posedge clk) begin
    if (proc) begin
      out_path_direct_r  <= ctrl.path_direct;
      out_is_probe_r     <= ctrl.is_probe;
      out_epoch_now_r    <= epoch_nxt;
      out_mode_now_r     <= mode_nxt;
      out_deadline_now_r <= deadline_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_path_direct  = out_path_direct_r;
  assign out_is_probe     = out_is_probe_r;
  assign out_epoch_now    = out_epoch_now_r;
  assign out_mode_now     = out_mode_now_r;
  assign out_deadline_now = out_deadline_now_r;

`ifndef SYNTH
  // The epoch only moves when an item is decided.
  a_epoch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !proc |=> $stable(epoch_r))
    else $error("epoch changed without an item");

  // A mode change moves the epoch by exactly one.
  a_epoch_step: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && ctrl.bump) |=> (epoch_r == EPOCH_WIDTH'($past(epoch_r) + 1'b1)))
    else $error("epoch did not advance by one on a mode change");

  // Outside the unavailable mode no deadline is held.
  a_deadline_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != cpnc_pkg::MODE_UNAVAILABLE) |-> (deadline_r == '0))
    else $error("deadline set outside the unavailable mode");

  // A fresh result reports the state it left behind.
  a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> (out_mode_now_r == mode_r) && (out_epoch_now_r == epoch_r)
             && (out_deadline_now_r == deadline_r))
    else $error("result does not match the updated state");
`endif

endmodule
